// ===== rtl/vnt_pkg.sv =====
package vnt_pkg;

  localparam int unsigned PIXEL_W = 12;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned IDX_W   = 2;

  // signed q2.16 noise value
  localparam int unsigned NOISE_W = 18;
  // smoothstep weight, 0..65536
  localparam int unsigned WEIGHT_W = 17;

  localparam logic [IDX_W-1:0] REG_COLOR_A    = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLOR_B    = 2'd1;
  localparam logic [IDX_W-1:0] REG_BASE_SCALE = 2'd2;

  localparam logic [COLOR_W-1:0] COLOR_A_RST    = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR_B_RST    = 24'hFFFFFF;
  localparam logic [SCALE_W-1:0] BASE_SCALE_RST = 16'd3277;

  localparam logic [31:0] HASH_ROW   = 32'd57;
  localparam logic [31:0] HASH_MUL   = 32'd15731;
  localparam logic [31:0] HASH_ADD_A = 32'd789221;
  localparam logic [31:0] HASH_ADD_B = 32'd1376312589;

endpackage

// ===== rtl/vnt_pixel_if.sv =====
interface vnt_pixel_if;
  import vnt_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_x;
  logic [PIXEL_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== rtl/vnt_color_if.sv =====
interface vnt_color_if;
  import vnt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/vnt_hash.sv =====
// corner hash, three stages from the registered seed
module vnt_hash (
  input  logic                                clk,
  input  logic                                adv,
  input  logic [31:0]                         seed,
  output logic signed [vnt_pkg::NOISE_W-1:0]  value
);
  import vnt_pkg::*;

  logic [31:0] sq;
  logic [31:0] seed_d1;
  logic [31:0] tt;
  logic [31:0] seed_d2;
  logic [31:0] m;

  assign m = seed_d2 * tt + HASH_ADD_B;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq      <= seed * seed;
      seed_d1 <= seed;
      tt      <= sq * HASH_MUL + HASH_ADD_A;
      seed_d2 <= seed_d1;
      value   <= NOISE_W'(65536) - $signed({1'b0, m[30:14]});
    end
  end
endmodule

// ===== rtl/vnt_octave.sv =====
// one octave of lattice value noise, six stages from the scaled coordinates
module vnt_octave #(
  parameter int unsigned PROD_W = 28,
  parameter int unsigned SHIFT  = 0
) (
  input  logic                               clk,
  input  logic                               adv,
  input  logic [PROD_W-1:0]                  prod_x,
  input  logic [PROD_W-1:0]                  prod_y,
  output logic signed [vnt_pkg::NOISE_W-1:0] noise
);
  import vnt_pkg::*;

  localparam int unsigned WIDE_W = 64;

  logic [WIDE_W-1:0] wide_x, wide_y;
  logic [30:0]       pos_x, pos_y;
  logic [31:0]       ix, iy, ix1, iy1;
  logic [31:0]       seed_c [4];

  // stage 1
  logic [31:0] seed_r [4];
  logic [31:0] ffx, ffy;
  logic [17:0] kx, ky;
  // stage 2
  logic [33:0] smx, smy;
  // stages 3 to 5
  logic [WEIGHT_W-1:0] sx3, sy3, sx4, sy4, sy5;
  logic signed [NOISE_W-1:0] corner [4];
  // stage 5
  logic signed [NOISE_W-1:0] i1, i2;
  logic signed [NOISE_W:0]   d1, d2, d3;
  logic signed [36:0]        p1, p2, p3;

  function automatic logic [31:0] seed_of(input logic [31:0] cx, input logic [31:0] cy);
    logic [31:0] n;
    n = cx + cy * HASH_ROW;
    return (n << 13) ^ n;
  endfunction

  always_comb begin
    wide_x    = WIDE_W'(prod_x) << SHIFT;
    wide_y    = WIDE_W'(prod_y) << SHIFT;
    pos_x     = wide_x[30:0];
    pos_y     = wide_y[30:0];
    ix        = 32'(pos_x[30:16]);
    iy        = 32'(pos_y[30:16]);
    ix1       = ix + 32'd1;
    iy1       = iy + 32'd1;
    seed_c[0] = seed_of(ix, iy);
    seed_c[1] = seed_of(ix1, iy);
    seed_c[2] = seed_of(ix, iy1);
    seed_c[3] = seed_of(ix1, iy1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seed_r <= seed_c;
      ffx    <= 32'(pos_x[15:0]) * 32'(pos_x[15:0]);
      ffy    <= 32'(pos_y[15:0]) * 32'(pos_y[15:0]);
      kx     <= 18'd196608 - {1'b0, pos_x[15:0], 1'b0};
      ky     <= 18'd196608 - {1'b0, pos_y[15:0], 1'b0};
      smx    <= 34'(ffx[31:16]) * 34'(kx);
      smy    <= 34'(ffy[31:16]) * 34'(ky);
      sx3    <= smx[32:16];
      sy3    <= smy[32:16];
      sx4    <= sx3;
      sy4    <= sy3;
      sy5    <= sy4;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_corner
    vnt_hash u_hash (
      .clk   (clk),
      .adv   (adv),
      .seed  (seed_r[c]),
      .value (corner[c])
    );
  end

  // floor blend via arithmetic shift
  always_comb begin
    d1 = (NOISE_W+1)'(corner[1]) - (NOISE_W+1)'(corner[0]);
    d2 = (NOISE_W+1)'(corner[3]) - (NOISE_W+1)'(corner[2]);
    d3 = (NOISE_W+1)'(i2) - (NOISE_W+1)'(i1);
    p1 = 37'(d1) * $signed({20'd0, sx4});
    p2 = 37'(d2) * $signed({20'd0, sx4});
    p3 = 37'(d3) * $signed({20'd0, sy5});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i1    <= corner[0] + NOISE_W'(p1 >>> 16);
      i2    <= corner[2] + NOISE_W'(p2 >>> 16);
      noise <= i1 + NOISE_W'(p3 >>> 16);
    end
  end
endmodule

// ===== rtl/value_noise_texture_shader.sv =====
// value noise texture shader: takes one pixel coordinate per item and returns its
// rgb colour as a blend of color_a and color_b weighted by OCTAVES octaves of
// lattice value noise (fractal sum, halved weight per octave, smoothstep blend).
// the block is a 13 stage pipeline: one item is accepted every cycle unless the colour
// side stalls; the rate is set by the pipeline itself, every stage holds one multiply
// at most. a stall on the colour side freezes the whole pipeline and drops ready on the
// pixel side. registers are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while the block is idle (not enforced here); index 3 is ignored.
module value_noise_texture_shader #(
  parameter int unsigned OCTAVES    = 4,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [vnt_pkg::IDX_W-1:0]    cfg_index,
  input  logic [vnt_pkg::CFG_W-1:0]    cfg_data,
  vnt_pixel_if.sink                    pix,
  vnt_color_if.source                  col
);
  import vnt_pkg::*;

  localparam int unsigned PROD_W  = COORD_BITS + SCALE_W;
  localparam int unsigned LAT     = 13;
  // weight sum of all octaves
  localparam longint unsigned DEN = (64'd1 << OCTAVES) - 64'd1;
  // shifted sum is nonnegative and below 2^(17+OCTAVES)
  localparam int unsigned SUM_W   = 17 + OCTAVES;
  localparam int unsigned SHK     = 18 + 2 * OCTAVES;
  localparam longint unsigned RECIP = ((64'd1 << SHK) + 2 * DEN - 64'd1) / (2 * DEN);
  localparam int unsigned RECIP_W = 19 + OCTAVES;
  localparam int unsigned QPROD_W = SUM_W + RECIP_W;

  // configuration registers
  logic [COLOR_W-1:0] color_a, color_b;
  logic [SCALE_W-1:0] base_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_a    <= COLOR_A_RST;
      color_b    <= COLOR_B_RST;
      base_scale <= BASE_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOR_A:    color_a    <= cfg_data[COLOR_W-1:0];
        REG_COLOR_B:    color_b    <= cfg_data[COLOR_W-1:0];
        REG_BASE_SCALE: base_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves together unless the output register holds an untaken item
  logic           adv;
  logic [LAT-1:0] vld;

  assign adv       = !vld[LAT-1] || col.ready;
  assign pix.ready = adv;
  assign col.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], pix.valid};
    end
  end

  // stage 1 coordinate register, stage 2 scaled coordinates
  logic [COORD_BITS-1:0] x, y;
  logic [PROD_W-1:0]     prod_x, prod_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      x      <= COORD_BITS'(pix.pixel_x);
      y      <= COORD_BITS'(pix.pixel_y);
      prod_x <= PROD_W'(x) * PROD_W'(base_scale);
      prod_y <= PROD_W'(y) * PROD_W'(base_scale);
    end
  end

  // octave lanes, stages 3 to 8
  logic signed [NOISE_W-1:0] noise [OCTAVES];

  for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
    vnt_octave #(
      .PROD_W (PROD_W),
      .SHIFT  (o)
    ) u_oct (
      .clk    (clk),
      .adv    (adv),
      .prod_x (prod_x),
      .prod_y (prod_y),
      .noise  (noise[o])
    );
  end

  // stage 9: weighted sum, offset by one so that it is never negative
  logic signed [SUM_W+1:0] acc_c;
  logic [SUM_W-1:0]        acc;

  always_comb begin
    acc_c = (SUM_W+2)'(65536) * (SUM_W+2)'(DEN);
    for (int o = 0; o < OCTAVES; o++) begin
      acc_c = acc_c + ((SUM_W+2)'(noise[o]) <<< (OCTAVES - 1 - o));
    end
  end

  // stages 10 and 11: divide by twice the weight sum through a reciprocal;
  // this gives the mapped and already clamped noise level directly
  logic [QPROD_W-1:0]  qprod;
  logic [WEIGHT_W-1:0] level;

  always_ff @(posedge clk) begin
    if (adv) begin
      acc   <= acc_c[SUM_W-1:0];
      qprod <= QPROD_W'(acc) * QPROD_W'(RECIP[RECIP_W-1:0]);
      level <= WEIGHT_W'(qprod >> SHK);
    end
  end

  // stages 12 and 13: per-channel blend between the two colours
  logic signed [CHAN_W:0]    cd [3];
  logic signed [CHAN_W+18:0] cp [3];
  logic [CHAN_W-1:0]         ca [3];
  logic [CHAN_W-1:0]         ca_d [3];
  logic [CHAN_W-1:0]         ch [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ca[c] = color_a[(2-c)*CHAN_W +: CHAN_W];
      cd[c] = $signed({1'b0, color_b[(2-c)*CHAN_W +: CHAN_W]}) - $signed({1'b0, ca[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        cp[c]   <= (CHAN_W+19)'(cd[c]) * $signed({{(CHAN_W+2){1'b0}}, level});
        ca_d[c] <= ca[c];
        ch[c]   <= ca_d[c] + CHAN_W'(cp[c] >>> 16);
      end
    end
  end

  assign col.red   = ch[0];
  assign col.green = ch[1];
  assign col.blue  = ch[2];
endmodule
